// ===== rtl/core/fra_pkg.sv =====
package fra_pkg;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_FORM,
        S_LOAD,
        S_GCD_CHK,
        S_GCD_ST,
        S_GCD_WT,
        S_QN_ST,
        S_QN_WT,
        S_QD_ST,
        S_QD_WT,
        S_STORE,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PAIR_RESULT,
        PAIR_FIRST,
        PAIR_SECOND
    } pair_t;

endpackage

// ===== rtl/core/fraction_arith_reduce_top.sv =====
// Fraction add/subtract/multiply/divide with reduction to lowest terms.
// Sequence: three products on the shared multiplier, then for each pair a
// Euclidean gcd (a check state and a divider pass per step) and two quotient
// passes; three gcds and six quotient passes run on one bit-serial divider.
// Throughput: one item at a time; a new transfer is taken only in idle.
// Reset (async, active low) clears the sequencer and the output valid.
module fraction_arith_reduce_top
    import fra_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   command,
    input  logic [OPERAND_WIDTH-1:0]     first_numer,
    input  logic [OPERAND_WIDTH-1:0]     first_denom,
    input  logic [OPERAND_WIDTH-1:0]     second_numer,
    input  logic [OPERAND_WIDTH-1:0]     second_denom,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2*OPERAND_WIDTH+1:0]   result_numer,
    output logic [2*OPERAND_WIDTH-1:0]   result_denom,
    output logic                         whole_result,
    output logic [OPERAND_WIDTH-1:0]     first_numer_reduced,
    output logic [OPERAND_WIDTH-1:0]     first_denom_reduced,
    output logic [OPERAND_WIDTH-1:0]     second_numer_reduced,
    output logic [OPERAND_WIDTH-1:0]     second_denom_reduced
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int DW = 2 * W + 1;
    localparam int NW = 2 * W + 2;

    state_t state_reg, state_next;

    logic [1:0]    cmd_reg, cmd_next;
    logic [W-1:0]  a_reg, a_next, b_reg, b_next, d_reg, d_next, e_reg, e_next;
    logic [1:0]    mul_idx_reg, mul_idx_next;
    pair_t         sel_reg, sel_next;
    logic [PW-1:0] pa_reg, pa_next, pb_reg, pb_next, pc_reg, pc_next;
    logic          neg_reg, neg_next;
    logic [DW-1:0] num_reg, num_next, den_reg, den_next;
    logic [DW-1:0] x_reg, x_next, y_reg, y_next;
    logic [DW-1:0] rm_reg, rm_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [W-1:0]  f1n_reg, f1n_next, f1d_reg, f1d_next;
    logic [W-1:0]  f2n_reg, f2n_next, f2d_reg, f2d_next;

    logic          out_valid_reg, out_valid_next;
    logic [NW-1:0] o_num_reg, o_num_next;
    logic [PW-1:0] o_den_reg, o_den_next;
    logic          o_whole_reg, o_whole_next;
    logic [W-1:0]  o_f1n_reg, o_f1n_next, o_f1d_reg, o_f1d_next;
    logic [W-1:0]  o_f2n_reg, o_f2n_next, o_f2d_reg, o_f2d_next;

    logic [W-1:0]  mul_a, mul_b;
    logic [PW-1:0] mul_p;
    logic [DW-1:0] sum_ext, pa_ext, pb_ext;
    logic          div_start, div_done;
    logic [DW-1:0] div_dividend, div_divisor, div_quo, div_rem;
    logic          out_free;
    logic [NW-1:0] mag_ext;

    fra_div #(.WIDTH(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    assign out_free = !out_valid_reg || !out_stall;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = a_reg;
        mul_b = e_reg;
        case (mul_idx_reg)
            2'd0:
            begin
                mul_a = a_reg;
                mul_b = (cmd_reg == CMD_MUL) ? d_reg : e_reg;
            end
            2'd1:
            begin
                mul_a = b_reg;
                mul_b = (cmd_reg == CMD_MUL) ? e_reg : d_reg;
            end
            default:
            begin
                mul_a = b_reg;
                mul_b = e_reg;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_MUL;
            S_MUL:     if (mul_idx_reg == 2'd2) state_next = S_FORM;
            S_FORM:    state_next = S_LOAD;
            S_LOAD:    state_next = S_GCD_CHK;
            S_GCD_CHK:
            begin
                if (y_reg != '0)
                    state_next = S_GCD_ST;
                else if (x_reg == '0)
                    state_next = S_STORE;
                else
                    state_next = S_QN_ST;
            end
            S_GCD_ST:  state_next = S_GCD_WT;
            S_GCD_WT:  if (div_done) state_next = S_GCD_CHK;
            S_QN_ST:   state_next = S_QN_WT;
            S_QN_WT:   if (div_done) state_next = S_QD_ST;
            S_QD_ST:   state_next = S_QD_WT;
            S_QD_WT:   if (div_done) state_next = S_STORE;
            S_STORE:   state_next = (sel_reg == PAIR_SECOND) ? S_OUT : S_LOAD;
            S_OUT:     if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        mul_idx_next   = mul_idx_reg;
        sel_next       = sel_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        pc_next        = pc_reg;
        neg_next       = neg_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        rm_next        = rm_reg;
        rd_next        = rd_reg;
        f1n_next       = f1n_reg;
        f1d_next       = f1d_reg;
        f2n_next       = f2n_reg;
        f2d_next       = f2d_reg;
        out_valid_next = out_valid_reg && out_stall;
        o_num_next     = o_num_reg;
        o_den_next     = o_den_reg;
        o_whole_next   = o_whole_reg;
        o_f1n_next     = o_f1n_reg;
        o_f1d_next     = o_f1d_reg;
        o_f2n_next     = o_f2n_reg;
        o_f2d_next     = o_f2d_reg;
        div_start      = 1'b0;
        div_dividend   = x_reg;
        div_divisor    = y_reg;
        in_stall       = (state_reg != S_IDLE);
        pa_ext         = {1'b0, pa_reg};
        pb_ext         = {1'b0, pb_reg};
        sum_ext        = pa_ext + pb_ext;
        mag_ext        = {1'b0, rm_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = command;
                    a_next       = first_numer;
                    b_next       = first_denom;
                    d_next       = second_numer;
                    e_next       = second_denom;
                    mul_idx_next = 2'd0;
                    sel_next     = PAIR_RESULT;
                end
            end
            S_MUL:
            begin
                case (mul_idx_reg)
                    2'd0:    pa_next = mul_p;
                    2'd1:    pb_next = mul_p;
                    default: pc_next = mul_p;
                endcase
                mul_idx_next = mul_idx_reg + 2'd1;
            end
            S_FORM:
            begin
                neg_next = 1'b0;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        num_next = sum_ext;
                        den_next = {1'b0, pc_reg};
                    end
                    CMD_SUB:
                    begin
                        if (pa_reg >= pb_reg)
                            num_next = pa_ext - pb_ext;
                        else
                        begin
                            num_next = pb_ext - pa_ext;
                            neg_next = 1'b1;
                        end
                        den_next = {1'b0, pc_reg};
                    end
                    default:
                    begin
                        num_next = pa_ext;
                        den_next = pb_ext;
                    end
                endcase
            end
            S_LOAD:
            begin
                x_next = num_reg;
                y_next = den_reg;
            end
            S_GCD_ST:
            begin
                div_start = 1'b1;
            end
            S_GCD_WT:
            begin
                if (div_done)
                begin
                    x_next = y_reg;
                    y_next = div_rem;
                end
            end
            S_QN_ST:
            begin
                div_start    = 1'b1;
                div_dividend = num_reg;
                div_divisor  = x_reg;
            end
            S_QN_WT:
            begin
                if (div_done)
                    num_next = div_quo;
            end
            S_QD_ST:
            begin
                div_start    = 1'b1;
                div_dividend = den_reg;
                div_divisor  = x_reg;
            end
            S_QD_WT:
            begin
                if (div_done)
                    den_next = div_quo;
            end
            S_STORE:
            begin
                case (sel_reg)
                    PAIR_RESULT:
                    begin
                        rm_next  = num_reg;
                        rd_next  = den_reg[PW-1:0];
                        num_next = {{(DW-W){1'b0}}, a_reg};
                        den_next = {{(DW-W){1'b0}}, b_reg};
                        sel_next = PAIR_FIRST;
                    end
                    PAIR_FIRST:
                    begin
                        f1n_next = num_reg[W-1:0];
                        f1d_next = den_reg[W-1:0];
                        num_next = {{(DW-W){1'b0}}, d_reg};
                        den_next = {{(DW-W){1'b0}}, e_reg};
                        sel_next = PAIR_SECOND;
                    end
                    default:
                    begin
                        f2n_next = num_reg[W-1:0];
                        f2d_next = den_reg[W-1:0];
                    end
                endcase
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_num_next     = (neg_reg && rm_reg != '0) ? (~mag_ext + 1'b1) : mag_ext;
                    o_den_next     = rd_reg;
                    o_whole_next   = (rm_reg == '0) || (rd_reg == PW'(1));
                    o_f1n_next     = f1n_reg;
                    o_f1d_next     = f1d_reg;
                    o_f2n_next     = f2n_reg;
                    o_f2d_next     = f2d_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        d_reg       <= d_next;
        e_reg       <= e_next;
        mul_idx_reg <= mul_idx_next;
        sel_reg     <= sel_next;
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        pc_reg      <= pc_next;
        neg_reg     <= neg_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        rm_reg      <= rm_next;
        rd_reg      <= rd_next;
        f1n_reg     <= f1n_next;
        f1d_reg     <= f1d_next;
        f2n_reg     <= f2n_next;
        f2d_reg     <= f2d_next;
        o_num_reg   <= o_num_next;
        o_den_reg   <= o_den_next;
        o_whole_reg <= o_whole_next;
        o_f1n_reg   <= o_f1n_next;
        o_f1d_reg   <= o_f1d_next;
        o_f2n_reg   <= o_f2n_next;
        o_f2d_reg   <= o_f2d_next;
    end

    assign out_valid            = out_valid_reg;
    assign result_numer         = o_num_reg;
    assign result_denom         = o_den_reg;
    assign whole_result         = o_whole_reg;
    assign first_numer_reduced  = o_f1n_reg;
    assign first_denom_reduced  = o_f1d_reg;
    assign second_numer_reduced = o_f2n_reg;
    assign second_denom_reduced = o_f2d_reg;

endmodule

// ===== rtl/core/fra_div.sv =====
module fra_div
    import fra_pkg::*;
#(
    parameter int WIDTH = 33
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder,
    output logic             done
);

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   diff;

    // one restoring step per cycle, MSB first
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[WIDTH-1]};
        diff      = rem_sh - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDTH])
            begin
                rem_next = diff[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule
